// ----- design/sf2d_pkg.sv -----
// shared widths, register codes and types for the 2d spring force unit
`timescale 1ns / 1ps

package sf2d_pkg;

    localparam int NUM_BODIES_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int POS_W       = 32;
    localparam int MASS_W      = 32;
    localparam int IDX_W       = 10;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 152;

    localparam int SQ_STEPS = 33;
    localparam int RAD_W    = 66;
    localparam int REM_W    = 36;
    localparam int ROOT_W   = 33;
    localparam int KE_W     = 65;
    localparam int NUM_W    = 97;
    localparam int DEN_W    = 65;
    localparam int QUO_W    = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_REST_LENGTH     = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SPRING_CONSTANT = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_INDEX_A         = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_INDEX_B         = t_cfg_idx'(3);

    typedef struct packed {
        logic [POS_W-1:0]  xm;
        logic [POS_W-1:0]  ym;
        logic              xneg;
        logic              yneg;
        logic [MASS_W-1:0] ma;
        logic [MASS_W-1:0] mb;
    } t_geo;

endpackage

// ----- design/sf2d_div.sv -----
// pipelined restoring divider, one quotient bit per stage, quotient capped at 2^31
`timescale 1ns / 1ps

module sf2d_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [sf2d_pkg::NUM_W-1:0]  i_num,
    input  logic [sf2d_pkg::DEN_W-1:0]  i_den,
    output logic                        o_valid,
    output logic [sf2d_pkg::QUO_W-1:0]  o_quo
);
    import sf2d_pkg::*;

    logic [NUM_W-1:0] w_rem [0:QUO_W];
    logic [DEN_W-1:0] w_den [0:QUO_W];
    logic [QUO_W-1:0] w_quo [0:QUO_W];
    logic             w_cap [0:QUO_W];
    logic             w_vld [0:QUO_W];

    assign w_rem[0] = i_num;
    assign w_den[0] = i_den;
    assign w_quo[0] = '0;
    assign w_cap[0] = 1'b0;
    assign w_vld[0] = i_valid;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0] w_trial;
        logic             w_hit;
        logic [NUM_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;
        logic [QUO_W-1:0] r_quo;
        logic             r_cap;
        logic             r_vld;

        assign w_trial = {{(NUM_W-DEN_W){1'b0}}, w_den[k]} << SH;
        assign w_hit   = !w_cap[k] && (w_rem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den <= w_den[k];
                if (k == 0) begin
                    r_rem <= w_rem[k];
                    r_quo <= w_quo[k];
                    r_cap <= w_hit;
                end else begin
                    r_rem <= w_hit ? w_rem[k] - w_trial : w_rem[k];
                    r_quo <= w_quo[k] | (w_hit ? (QUO_W'(1) << SH) : '0);
                    r_cap <= w_cap[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[k];
            end
        end

        assign w_rem[k+1] = r_rem;
        assign w_den[k+1] = r_den;
        assign w_quo[k+1] = r_quo;
        assign w_cap[k+1] = r_cap;
        assign w_vld[k+1] = r_vld;
    end

    assign o_valid = w_vld[QUO_W];
    assign o_quo   = w_cap[QUO_W] ? (QUO_W'(1) << (QUO_W - 1)) : w_quo[QUO_W];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[QUO_W] && !w_cap[QUO_W]) |->
            (w_rem[QUO_W] < {{(NUM_W-DEN_W){1'b0}}, w_den[QUO_W]}))
        else $error("divider remainder not below divisor");

    a_cap_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[QUO_W] && w_cap[QUO_W]) |-> (w_quo[QUO_W] == '0))
        else $error("capped quotient picked up bits");

    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_vld[1]) |=> w_vld[2])
        else $error("divider valid lost");

endmodule

// ----- design/spring_force_2d_unit.sv -----
// 2d hooke spring force unit, fully pipelined
// beats pass input, squares, sum, sqrt, extension, products, numerators, dividers, output regs
// one beat per cycle unless the skid is full; the sqrt (33 stages) and dividers (32) set depth
// one skid register at the output takes a result while the sink stalls
// synchronous active-low reset clears valid bits and loads register defaults
`timescale 1ns / 1ps

module spring_force_2d_unit #(
    parameter int NUM_BODIES = sf2d_pkg::NUM_BODIES_DEF,
    parameter int FRAC_BITS  = sf2d_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // a_x, a_y, b_x, b_y, mass_a, mass_b
    input  logic [sf2d_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // force_a_x, force_a_y, force_b_x, force_b_y, target_a, target_b, zero pad
    output logic [sf2d_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sf2d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sf2d_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sf2d_pkg::*;

    localparam int ST_SQRT0 = 3;
    localparam int ST_E     = ST_SQRT0 + SQ_STEPS;
    localparam int ST_NUM   = ST_E + 3;
    localparam int N_PRE    = ST_NUM + 1;
    localparam int IDX_RECIP = ((1 << 20) + NUM_BODIES - 1) / NUM_BODIES;
    localparam bit IDX_WRAP  = NUM_BODIES < (1 << IDX_W);

    // configuration
    logic [31:0]      r_rest;
    logic [31:0]      r_k;
    logic [IDX_W-1:0] r_idx_a;
    logic [IDX_W-1:0] r_idx_b;
    logic [29:0]      w_idx_prod;
    logic [IDX_W-1:0] w_idx_q;
    logic [19:0]      w_idx_qn;
    logic [19:0]      w_idx_r;
    logic [IDX_W-1:0] w_idx_red;

    assign w_idx_prod = 30'(i_cfg_data[IDX_W-1:0]) * 30'(IDX_RECIP);
    assign w_idx_q    = w_idx_prod[29:20];
    assign w_idx_qn   = 20'(w_idx_q) * 20'(NUM_BODIES);
    assign w_idx_r    = 20'(i_cfg_data[IDX_W-1:0]) - w_idx_qn;
    assign w_idx_red  = !IDX_WRAP ? i_cfg_data[IDX_W-1:0] :
                        (w_idx_r >= 20'(NUM_BODIES)) ? IDX_W'(w_idx_r - 20'(NUM_BODIES)) :
                        IDX_W'(w_idx_r);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= 32'd1 << FRAC_BITS;
            r_k     <= 32'd1 << FRAC_BITS;
            r_idx_a <= IDX_W'(0);
            r_idx_b <= IDX_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REST_LENGTH:     r_rest  <= i_cfg_data;
                CFG_SPRING_CONSTANT: r_k     <= i_cfg_data;
                CFG_INDEX_A:         r_idx_a <= w_idx_red;
                CFG_INDEX_B:         r_idx_b <= w_idx_red;
                default: ;
            endcase
        end
    end

    // flow control
    logic                   w_adv;
    logic [N_PRE-1:0]       r_vld;
    logic [3:0]             w_dvld;
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out;
    logic                   r_skid_vld;
    logic [OUT_TDATA_W-1:0] r_skid;

    assign w_adv           = !r_skid_vld;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[N_PRE-2:0], i_s_axis_tvalid};
            r_out_vld <= &w_dvld;
        end
    end

    // difference and magnitude
    logic [32:0]  w_dx;
    logic [32:0]  w_dy;
    logic [32:0]  w_dx_n;
    logic [32:0]  w_dy_n;
    t_geo         w_geo_in;
    t_geo         r_geo0;

    assign w_dx   = {i_s_axis_tdata[95], i_s_axis_tdata[95:64]}
                  - {i_s_axis_tdata[31], i_s_axis_tdata[31:0]};
    assign w_dy   = {i_s_axis_tdata[127], i_s_axis_tdata[127:96]}
                  - {i_s_axis_tdata[63], i_s_axis_tdata[63:32]};
    assign w_dx_n = 33'd0 - w_dx;
    assign w_dy_n = 33'd0 - w_dy;

    always_comb begin
        w_geo_in.xm   = w_dx[32] ? w_dx_n[31:0] : w_dx[31:0];
        w_geo_in.ym   = w_dy[32] ? w_dy_n[31:0] : w_dy[31:0];
        w_geo_in.xneg = w_dx[32];
        w_geo_in.yneg = w_dy[32];
        w_geo_in.ma   = (i_s_axis_tdata[159:128] == '0) ? 32'd1 : i_s_axis_tdata[159:128];
        w_geo_in.mb   = (i_s_axis_tdata[191:160] == '0) ? 32'd1 : i_s_axis_tdata[191:160];
    end

    // squares and sum
    logic [63:0]      r_xsq;
    logic [63:0]      r_ysq;
    t_geo             r_geo1;
    logic [RAD_W-2:0] r_sum;
    t_geo             r_geo2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_geo0 <= w_geo_in;
            r_xsq  <= 64'(r_geo0.xm) * 64'(r_geo0.xm);
            r_ysq  <= 64'(r_geo0.ym) * 64'(r_geo0.ym);
            r_geo1 <= r_geo0;
            r_sum  <= {1'b0, r_xsq} + {1'b0, r_ysq};
            r_geo2 <= r_geo1;
        end
    end

    // square root, one result bit per stage
    logic [RAD_W-1:0]  w_sq_rad  [0:SQ_STEPS-1];
    logic [REM_W-1:0]  w_sq_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0] w_sq_root [0:SQ_STEPS];
    t_geo              w_sq_geo  [0:SQ_STEPS];

    assign w_sq_rad[0]  = {1'b0, r_sum};
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_geo[0]  = r_geo2;

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
        localparam int P = SQ_STEPS - 1 - s;
        logic [REM_W-1:0]  w_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        t_geo              r_geo;

        assign w_sh    = {w_sq_rem[s][REM_W-3:0], w_sq_rad[s][2*P+1 -: 2]};
        assign w_trial = REM_W'({w_sq_root[s], 2'b01});
        assign w_ge    = w_sh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem  <= w_ge ? w_sh - w_trial : w_sh;
                r_root <= {w_sq_root[s][ROOT_W-2:0], w_ge};
                r_geo  <= w_sq_geo[s];
            end
        end

        if (s < SQ_STEPS - 1) begin : g_rad
            logic [RAD_W-1:0] r_rad;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_rad <= w_sq_rad[s];
                end
            end
            assign w_sq_rad[s+1] = r_rad;
        end

        assign w_sq_rem[s+1]  = r_rem;
        assign w_sq_root[s+1] = r_root;
        assign w_sq_geo[s+1]  = r_geo;
    end

    // extension and coincident points
    logic [ROOT_W-1:0] w_d;
    t_geo              w_geo_d;
    logic              w_dz;
    logic [ROOT_W-1:0] w_rest_x;
    logic              w_eneg;
    logic [ROOT_W-1:0] w_emag;

    assign w_d      = w_sq_root[SQ_STEPS];
    assign w_geo_d  = w_sq_geo[SQ_STEPS];
    assign w_dz     = w_d == '0;
    assign w_rest_x = {1'b0, r_rest};
    assign w_eneg   = w_d < w_rest_x;
    assign w_emag   = w_eneg ? w_rest_x - w_d : w_d - w_rest_x;

    logic [ROOT_W-1:0] r_e_d;
    logic [ROOT_W-1:0] r_e_emag;
    logic [31:0]       r_e_xm;
    logic [31:0]       r_e_ym;
    logic              r_e_sx;
    logic              r_e_sy;
    logic [31:0]       r_e_ma;
    logic [31:0]       r_e_mb;

    logic [KE_W-1:0]   r_m_ke;
    logic [DEN_W-1:0]  r_m_dena;
    logic [DEN_W-1:0]  r_m_denb;
    logic [31:0]       r_m_xm;
    logic [31:0]       r_m_ym;
    logic              r_m_sx;
    logic              r_m_sy;

    logic [63:0]       r_p_xl;
    logic [64:0]       r_p_xh;
    logic [63:0]       r_p_yl;
    logic [64:0]       r_p_yh;
    logic [DEN_W-1:0]  r_p_dena;
    logic [DEN_W-1:0]  r_p_denb;
    logic              r_p_sx;
    logic              r_p_sy;

    logic [NUM_W-1:0]  r_n_numx;
    logic [NUM_W-1:0]  r_n_numy;
    logic [DEN_W-1:0]  r_n_dena;
    logic [DEN_W-1:0]  r_n_denb;
    logic              r_n_sx;
    logic              r_n_sy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_d    <= w_dz ? ROOT_W'(1) : w_d;
            r_e_emag <= w_emag;
            r_e_xm   <= w_dz ? 32'd1 : w_geo_d.xm;
            r_e_ym   <= w_dz ? 32'd0 : w_geo_d.ym;
            r_e_sx   <= w_eneg ^ (w_geo_d.xneg & ~w_dz);
            r_e_sy   <= w_eneg ^ (w_geo_d.yneg & ~w_dz);
            r_e_ma   <= w_geo_d.ma;
            r_e_mb   <= w_geo_d.mb;

            r_m_ke   <= KE_W'(r_k) * KE_W'(r_e_emag);
            r_m_dena <= DEN_W'(r_e_d) * DEN_W'(r_e_ma);
            r_m_denb <= DEN_W'(r_e_d) * DEN_W'(r_e_mb);
            r_m_xm   <= r_e_xm;
            r_m_ym   <= r_e_ym;
            r_m_sx   <= r_e_sx;
            r_m_sy   <= r_e_sy;

            r_p_xl   <= 64'(r_m_ke[31:0]) * 64'(r_m_xm);
            r_p_xh   <= 65'(r_m_ke[KE_W-1:32]) * 65'(r_m_xm);
            r_p_yl   <= 64'(r_m_ke[31:0]) * 64'(r_m_ym);
            r_p_yh   <= 65'(r_m_ke[KE_W-1:32]) * 65'(r_m_ym);
            r_p_dena <= r_m_dena;
            r_p_denb <= r_m_denb;
            r_p_sx   <= r_m_sx;
            r_p_sy   <= r_m_sy;

            r_n_numx <= NUM_W'(r_p_xl) + (NUM_W'(r_p_xh) << 32);
            r_n_numy <= NUM_W'(r_p_yl) + (NUM_W'(r_p_yh) << 32);
            r_n_dena <= r_p_dena;
            r_n_denb <= r_p_denb;
            r_n_sx   <= r_p_sx;
            r_n_sy   <= r_p_sy;
        end
    end

    // four division lanes: a_x, a_y, b_x, b_y
    logic [NUM_W-1:0] w_dnum [0:3];
    logic [DEN_W-1:0] w_dden [0:3];
    logic [QUO_W-1:0] w_dquo [0:3];

    assign w_dnum[0] = r_n_numx;
    assign w_dnum[1] = r_n_numy;
    assign w_dnum[2] = r_n_numx;
    assign w_dnum[3] = r_n_numy;
    assign w_dden[0] = r_n_dena;
    assign w_dden[1] = r_n_dena;
    assign w_dden[2] = r_n_denb;
    assign w_dden[3] = r_n_denb;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        sf2d_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (r_vld[ST_NUM]),
            .i_num   (w_dnum[l]),
            .i_den   (w_dden[l]),
            .o_valid (w_dvld[l]),
            .o_quo   (w_dquo[l])
        );
    end

    // sign bits ride alongside the dividers
    logic [1:0] w_sgn [0:QUO_W];

    assign w_sgn[0] = {r_n_sy, r_n_sx};

    for (genvar k = 0; k < QUO_W; k++) begin : g_sgn
        logic [1:0] r_sgn;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sgn <= w_sgn[k];
            end
        end
        assign w_sgn[k+1] = r_sgn;
    end

    function automatic logic [31:0] f_sat(input logic neg, input logic [QUO_W-1:0] q);
        if (neg) begin
            return 32'd0 - q;
        end else if (q[QUO_W-1]) begin
            return 32'h7FFF_FFFF;
        end else begin
            return q;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {4'b0, r_idx_b, r_idx_a,
                      f_sat(!w_sgn[QUO_W][1], w_dquo[3]),
                      f_sat(!w_sgn[QUO_W][0], w_dquo[2]),
                      f_sat(w_sgn[QUO_W][1], w_dquo[1]),
                      f_sat(w_sgn[QUO_W][0], w_dquo[0])};
        end
    end

    // output skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            if (r_out_vld && !i_m_axis_tready) begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && r_out_vld && !i_m_axis_tready) begin
            r_skid <= r_out;
        end
    end

    assign o_m_axis_tvalid = r_skid_vld | r_out_vld;
    assign o_m_axis_tdata  = r_skid_vld ? r_skid : r_out;

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_E-1] |-> (w_sq_rem[SQ_STEPS] <= REM_W'({w_sq_root[SQ_STEPS], 1'b0})))
        else $error("square root remainder out of bound");

    a_skid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid loaded without a stalled beat");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_dvld) == 0) || ($countones(w_dvld) == 4))
        else $error("division lanes out of step");

    a_pipe_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[0]) |=> r_vld[1])
        else $error("beat lost in pipeline");

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the 2d spring force unit with random traffic and configs
`timescale 1ns / 1ps

module tb_top;
    import sf2d_pkg::*;

    localparam t_cfg_idx CFG_UNMAPPED = t_cfg_idx'(200);
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 600;
    localparam int HOLD_AT    = 500;

    typedef struct packed {
        logic signed [31:0] fax;
        logic signed [31:0] fay;
        logic signed [31:0] fbx;
        logic signed [31:0] fby;
        logic [IDX_W-1:0]   ta;
        logic [IDX_W-1:0]   tb;
    } t_force;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    logic [31:0]      rest_len = 32'd65536;
    logic [31:0]      stiffness = 32'd65536;
    logic [IDX_W-1:0] body_a = 10'd0;
    logic [IDX_W-1:0] body_b = 10'd1;

    logic [IN_TDATA_W-1:0] position_q[$];
    t_force                force_q[$];
    int                    err_count = 0;
    int                    results_seen = 0;

    spring_force_2d_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // one increment: k*e*c / (d*m), capped, signed, optionally negated, saturated
    function automatic logic signed [31:0] increment(logic [127:0] ke, logic [32:0] c,
                                                     logic neg, logic [32:0] d,
                                                     logic [31:0] m, logic flip);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic signed [40:0] v;
        num = ke * 128'(c);
        den = 128'(d) * 128'(m);
        if (num >= (den << 31)) q = 128'h8000_0000;
        else q = num / den;
        v = neg ? -$signed({1'b0, q[39:0]}) : $signed({1'b0, q[39:0]});
        if (flip) v = -v;
        if (v > 41'sd2147483647) v = 41'sd2147483647;
        if (v < -41'sd2147483648) v = -41'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_force predict_force(logic [IN_TDATA_W-1:0] beat);
        logic signed [32:0] dx, dy;
        logic [32:0] xm, ym;
        logic [65:0] sumsq;
        logic [67:0] rem, trial;
        logic [32:0] root;
        logic signed [35:0] ext;
        logic [34:0] emag;
        logic eneg, xneg, yneg;
        logic [31:0] ma, mb;
        logic [127:0] ke;
        t_force r;
        dx = $signed({beat[95], beat[95:64]}) - $signed({beat[31], beat[31:0]});
        dy = $signed({beat[127], beat[127:96]}) - $signed({beat[63], beat[63:32]});
        xneg = dx < 0;
        yneg = dy < 0;
        xm = xneg ? -dx : dx;
        ym = yneg ? -dy : dy;
        sumsq = 66'(xm) * 66'(xm) + 66'(ym) * 66'(ym);
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'((sumsq >> (2 * i)) & 66'd3);
            trial = ({35'd0, root} << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 33'd1;
            end else begin
                root = root << 1;
            end
        end
        ext = $signed({3'b0, root}) - $signed({4'b0, rest_len});
        eneg = ext < 0;
        emag = 35'(eneg ? -ext : ext);
        if (root == 0) begin
            root = 33'd1;
            xm = 33'd1;
            ym = 33'd0;
            xneg = 1'b0;
            yneg = 1'b0;
        end
        ma = (beat[159:128] == 0) ? 32'd1 : beat[159:128];
        mb = (beat[191:160] == 0) ? 32'd1 : beat[191:160];
        ke = 128'(stiffness) * 128'(emag);
        r.fax = increment(ke, xm, eneg != xneg, root, ma, 1'b0);
        r.fay = increment(ke, ym, eneg != yneg, root, ma, 1'b0);
        r.fbx = increment(ke, xm, eneg != xneg, root, mb, 1'b1);
        r.fby = increment(ke, ym, eneg != yneg, root, mb, 1'b1);
        r.ta = body_a;
        r.tb = body_b;
        return r;
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(1, 1 << 20);
            2: return 32'd65536 + $urandom_range(0, 1 << 18);
            3: return ($urandom_range(0, 9) == 0) ? 32'd0 : 32'd1;
            default: return $urandom_range(1 << 12, 1 << 24);
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_beat();
        logic [31:0] ax, ay, bx, by;
        ax = $urandom;
        ay = $urandom;
        bx = $urandom;
        by = $urandom;
        case ($urandom_range(0, 6))
            1, 2: begin
                ax = $signed(ax) >>> 3;
                ay = $signed(ay) >>> 3;
                bx = ax + ($signed($urandom) >>> $urandom_range(8, 14));
                by = ay + ($signed($urandom) >>> $urandom_range(8, 14));
            end
            3: begin
                bx = ax;
                by = ay;
            end
            4: begin
                if ($urandom_range(0, 1)) by = ay;
                else bx = ax;
            end
            5: begin
                ax = pick_edge();
                ay = pick_edge();
                bx = pick_edge();
                by = pick_edge();
            end
            default: ;
        endcase
        return {pick_mass(), pick_mass(), by, bx, ay, ax};
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) begin
                case (idx)
                    CFG_REST_LENGTH:     rest_len  = value;
                    CFG_SPRING_CONSTANT: stiffness = value;
                    CFG_INDEX_A:         body_a = IDX_W'(value[IDX_W-1:0] % NUM_BODIES_DEF);
                    CFG_INDEX_B:         body_b = IDX_W'(value[IDX_W-1:0] % NUM_BODIES_DEF);
                    default: ;
                endcase
                i_cfg_valid <= 1'b0;
                break;
            end
        end
    endtask

    task automatic drain();
        while (position_q.size() != 0 || i_s_axis_tvalid || force_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic                  nxt_valid;
        logic [IN_TDATA_W-1:0] nxt_data;
        nxt_valid = i_s_axis_tvalid;
        nxt_data  = i_s_axis_tdata;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                force_q.push_back(predict_force(i_s_axis_tdata));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (position_q.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = position_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
    end

    // receiver: stall pattern that changes mode, plus one long hold-off
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    bit held_once = 0;
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
        if (!held_once && results_seen >= HOLD_AT) begin
            held_once = 1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                2: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_force want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (force_q.size() == 0) begin
                $display("unexpected result beat at %0t", $realtime);
                err_count++;
            end else begin
                want = force_q.pop_front();
                if (o_m_axis_tdata[31:0] !== want.fax)
                    report_mismatch("force_a_x", o_m_axis_tdata[31:0], want.fax);
                if (o_m_axis_tdata[63:32] !== want.fay)
                    report_mismatch("force_a_y", o_m_axis_tdata[63:32], want.fay);
                if (o_m_axis_tdata[95:64] !== want.fbx)
                    report_mismatch("force_b_x", o_m_axis_tdata[95:64], want.fbx);
                if (o_m_axis_tdata[127:96] !== want.fby)
                    report_mismatch("force_b_y", o_m_axis_tdata[127:96], want.fby);
                if (o_m_axis_tdata[137:128] !== want.ta)
                    report_mismatch("target_a", 32'(o_m_axis_tdata[137:128]), 32'(want.ta));
                if (o_m_axis_tdata[147:138] !== want.tb)
                    report_mismatch("target_b", 32'(o_m_axis_tdata[147:138]), 32'(want.tb));
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] mx;
        mx = 32'hffff_ffff;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, coincident points, zero mass, axis cases, under reset config
        position_q.push_back({32'd1, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h8000_0000, 32'h8000_0000});
        position_q.push_back({32'd1, 32'd1, 32'h8000_0000, 32'h8000_0000,
                              32'h7fff_ffff, 32'h7fff_ffff});
        position_q.push_back({mx, mx, 32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000});
        position_q.push_back({32'd65536, 32'd65536, 32'h1234, 32'h5678, 32'h1234, 32'h5678});
        position_q.push_back({32'd0, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0});
        position_q.push_back({32'd0, 32'd65536, 32'h0, 32'h30000, 32'h0, 32'h0});
        position_q.push_back({32'd65536, 32'd0, 32'h30000, 32'h0, 32'h0, 32'h0});
        position_q.push_back({32'd65536, 32'd65536, 32'h0, 32'hfffd0000, 32'h0, 32'h0});
        position_q.push_back({32'd65536, 32'd65536, 32'hfffd0000, 32'h0, 32'h0, 32'h0});
        position_q.push_back({32'd65536, 32'd65536, 32'h8000, 32'h0, 32'h0, 32'h0});
        position_q.push_back({32'd65536, 32'd65536, 32'h10000, 32'h0, 32'h0, 32'h0});
        position_q.push_back({32'd2, 32'd3, 32'h40000, 32'h30000, 32'hffff0000, 32'h10000});
        position_q.push_back({mx, mx, mx, mx, mx, mx});
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SPRING_CONSTANT, 32'd0);
                    write_reg(CFG_INDEX_A, 32'd1023);
                    write_reg(CFG_INDEX_B, 32'd0);
                end
                1: begin
                    write_reg(CFG_SPRING_CONSTANT, mx);
                    write_reg(CFG_REST_LENGTH, mx);
                    write_reg(CFG_INDEX_A, 32'hffff_fc05);
                end
                2: begin
                    write_reg(CFG_REST_LENGTH, 32'd0);
                    write_reg(CFG_INDEX_B, mx);
                end
                3: begin
                    write_reg(CFG_UNMAPPED, 32'h5a5a_5a5a);
                    write_reg(CFG_SPRING_CONSTANT, 32'd65536);
                    write_reg(CFG_REST_LENGTH, 32'd65536);
                end
                default: begin
                    write_reg(CFG_REST_LENGTH, $urandom_range(0, 1) ? $urandom
                                                                    : $urandom_range(0, 1 << 22));
                    write_reg(CFG_SPRING_CONSTANT, $urandom_range(0, 1) ? $urandom
                                                                        : $urandom_range(0, 1 << 20));
                    write_reg(CFG_INDEX_A, $urandom);
                    write_reg(CFG_INDEX_B, $urandom);
                end
            endcase
            for (int n = 0; n < 210; n++) position_q.push_back(random_beat());
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sf2d_pkg.sv
design/sf2d_div.sv
design/spring_force_2d_unit.sv
verif/tb_top.sv
